FILE: rtl/core/integer_rank_assigner_unit_assert.svh
// ----------------------------------------------------------------------------
// integer_rank_assigner_unit assertion macros
// shared property forms for the rank assigner checks
// ----------------------------------------------------------------------------
`ifndef INTEGER_RANK_ASSIGNER_UNIT_ASSERT_SVH
`define INTEGER_RANK_ASSIGNER_UNIT_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define IRANK_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("irank check failed");

// next-cycle implication under synchronous active-low reset
`define IRANK_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("irank check failed");

`endif

FILE: rtl/core/irank_pkg.sv
// ----------------------------------------------------------------------------
// irank_pkg
// shared constants and types of the integer rank assigner
// ----------------------------------------------------------------------------
package irank_pkg;

    localparam int MaxItems = 64;
    localparam int IdxW     = $clog2(MaxItems);
    localparam int CntW     = IdxW + 1;
    localparam int ValW     = 32;
    localparam int RankW    = 6;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_LATCH,
        S_READ,
        S_CMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic en;
    } cmp_ctl_t;

endpackage

FILE: rtl/core/integer_rank_assigner_unit.sv
// ----------------------------------------------------------------------------
// integer_rank_assigner_unit
// ranks a set of signed 32-bit values and returns ranks in arrival order
// ----------------------------------------------------------------------------
// Values are loaded one beat per cycle, up to 64 per set; further beats are
// dropped and flagged. The beat with tlast closes the set, and the block then
// leaves ready low and emits one rank per stored value in arrival order. Each
// rank is the number of stored values strictly smaller, found by one shared
// comparator walking the store entry by entry through its single read port;
// the block loads again only after the last rank is taken. tuser flags equal
// values and a dropped load.
// ----------------------------------------------------------------------------
`include "integer_rank_assigner_unit_assert.svh"

module integer_rank_assigner_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] rank, [7:6] zero
    output logic [1:0]  m_tuser,   // [0] duplicate_seen, [1] overflow_seen
    output logic        m_tlast    // last_rank
);

    irank_pkg::state_t                state_reg, state_next;
    logic [irank_pkg::CntW-1:0]       count_reg, count_next;
    logic                             ovf_reg, ovf_next;
    logic [irank_pkg::IdxW-1:0]       k_reg, k_next;
    logic [irank_pkg::IdxW-1:0]       j_reg, j_next;
    logic [irank_pkg::ValW-1:0]       x_reg, x_next;

    logic                             in_beat, out_beat, not_full;
    logic                             j_last, k_last;
    logic                             wr_en;
    logic [irank_pkg::IdxW-1:0]       rd_addr;
    logic [irank_pkg::ValW-1:0]       rd_data;
    irank_pkg::cmp_ctl_t              cmp_ctl;
    logic [irank_pkg::IdxW-1:0]       less_cnt;
    logic                             dup;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign not_full = count_reg < irank_pkg::CntW'(irank_pkg::MaxItems);
    assign j_last   = {1'b0, j_reg} == count_reg - irank_pkg::CntW'(1);
    assign k_last   = {1'b0, k_reg} == count_reg - irank_pkg::CntW'(1);

    irank_store u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[irank_pkg::IdxW-1:0]),
        .wr_data  (s_tdata),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    irank_cmp u_cmp (
        .aclk     (aclk),
        .ctl      (cmp_ctl),
        .ref_val  (x_reg),
        .cand_val (rd_data),
        .less_cnt (less_cnt),
        .dup      (dup)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            irank_pkg::S_LOAD: begin
                if (in_beat && s_tlast) begin
                    state_next = irank_pkg::S_FETCH;
                end
            end
            irank_pkg::S_FETCH: state_next = irank_pkg::S_LATCH;
            irank_pkg::S_LATCH: state_next = irank_pkg::S_READ;
            irank_pkg::S_READ:  state_next = irank_pkg::S_CMP;
            irank_pkg::S_CMP: begin
                state_next = j_last ? irank_pkg::S_EMIT : irank_pkg::S_READ;
            end
            irank_pkg::S_EMIT: begin
                if (out_beat) begin
                    state_next = k_last ? irank_pkg::S_LOAD : irank_pkg::S_FETCH;
                end
            end
            default: state_next = irank_pkg::S_LOAD;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        wr_en         = 1'b0;
        rd_addr       = j_reg;
        cmp_ctl.clear = 1'b0;
        cmp_ctl.en    = 1'b0;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        x_next        = x_reg;
        case (state_reg)
            irank_pkg::S_LOAD: begin
                s_tready = 1'b1;
                k_next   = '0;
                if (in_beat) begin
                    if (not_full) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            irank_pkg::S_FETCH: begin
                rd_addr = k_reg;
            end
            irank_pkg::S_LATCH: begin
                x_next        = rd_data;
                j_next        = '0;
                cmp_ctl.clear = 1'b1;
            end
            irank_pkg::S_READ: begin
                rd_addr = j_reg;
            end
            irank_pkg::S_CMP: begin
                cmp_ctl.en = 1'b1;
                j_next     = j_reg + 1'b1;
            end
            irank_pkg::S_EMIT: begin
                m_tvalid = 1'b1;
                if (out_beat) begin
                    if (k_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= irank_pkg::S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
        k_reg <= k_next;
        j_reg <= j_next;
        x_reg <= x_next;
    end

    // result fields stay fixed for the whole emit state
    assign m_tdata = {{(8 - irank_pkg::RankW){1'b0}}, irank_pkg::RankW'(less_cnt)};
    assign m_tuser = {ovf_reg, dup};
    assign m_tlast = k_last;

    `IRANK_ASSERT_IMP(a_no_load_while_emit, aclk, aresetn, s_tready, !m_tvalid)
    `IRANK_ASSERT_IMP(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= irank_pkg::CntW'(irank_pkg::MaxItems))
    `IRANK_ASSERT_NXT(a_set_done_reload, aclk, aresetn, out_beat && m_tlast, s_tready && count_reg == '0 && !ovf_reg)
    `IRANK_ASSERT_IMP(a_scan_in_set, aclk, aresetn, state_reg == irank_pkg::S_READ, {1'b0, j_reg} < count_reg)

endmodule

FILE: rtl/core/irank_store.sv
// ----------------------------------------------------------------------------
// irank_store
// arrival order value memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module irank_store (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [irank_pkg::IdxW-1:0]          wr_addr,
    input  logic [irank_pkg::ValW-1:0]          wr_data,
    input  logic [irank_pkg::IdxW-1:0]          rd_addr,
    output logic [irank_pkg::ValW-1:0]          rd_data
);

    logic [irank_pkg::ValW-1:0] mem [irank_pkg::MaxItems];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/irank_cmp.sv
// ----------------------------------------------------------------------------
// irank_cmp
// shared signed comparator with smaller-value counter and equal detector
// ----------------------------------------------------------------------------
module irank_cmp (
    input  logic                                aclk,
    input  irank_pkg::cmp_ctl_t                 ctl,
    input  logic [irank_pkg::ValW-1:0]          ref_val,
    input  logic [irank_pkg::ValW-1:0]          cand_val,
    output logic [irank_pkg::IdxW-1:0]          less_cnt,
    output logic                                dup
);

    logic [irank_pkg::IdxW-1:0] less_reg, less_next;
    logic [1:0]                 eq_reg, eq_next;
    logic                       is_less, is_eq;

    assign is_less = $signed(cand_val) < $signed(ref_val);
    assign is_eq   = cand_val == ref_val;

    always_comb begin
        less_next = less_reg;
        eq_next   = eq_reg;
        if (ctl.clear) begin
            less_next = '0;
            eq_next   = '0;
        end else if (ctl.en) begin
            if (is_less) begin
                less_next = less_reg + 1'b1;
            end
            // saturate: the value matches itself once, a second match is a duplicate
            if (is_eq && eq_reg != 2'd2) begin
                eq_next = eq_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        less_reg <= less_next;
        eq_reg   <= eq_next;
    end

    assign less_cnt = less_reg;
    assign dup      = eq_reg == 2'd2;

endmodule
